>>> design/cfd_pkg.sv
// ============================================================================
// cfd_pkg
// Shared constants and types for the checksummed frame deframer.
// ============================================================================
`default_nettype none

package cfd_pkg;

    // Receive buffer size that bounds the accepted length byte
    localparam int BUFFER_BYTES = 64;

    // Header marker, and the legal range of the length byte
    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] LEN_MIN     = 8'd2;
    localparam logic [7:0] LEN_MAX     = 8'(BUFFER_BYTES - 4);

    // Payload countdown holds at most LEN_MAX - 2
    localparam int LEFT_W = $clog2(BUFFER_BYTES - 5);

    // Frame status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ADDR = 2'd1,
        ST_BAD_LEN  = 2'd2,
        ST_BAD_SUM  = 2'd3
    } frame_status_t;

    // Result offered by the parser for the byte currently presented
    typedef struct packed {
        logic          emit;
        frame_status_t status;
        logic [7:0]    device_error;
        logic [15:0]   raw_position;
    } cfd_result_t;

endpackage : cfd_pkg

`default_nettype wire

>>> design/cfd_parser.sv
// ============================================================================
// cfd_parser
// Byte-at-a-time frame parser: header hunt, address and length checks,
// running checksum and position capture. One byte consumed per step.
// ============================================================================
`default_nettype none

module cfd_parser
    import cfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,         // consume rx_byte this cycle
    input  wire logic [7:0]  rx_byte,
    input  wire logic [7:0]  own_address,
    output cfd_result_t      result        // result the byte would give
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ADDR,
        PH_LEN,
        PH_ERR,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t              phase_reg,     phase_next;
    logic [1:0]          seen_reg,      seen_next;
    logic [LEFT_W-1:0]   left_reg,      left_next;
    logic [1:0]          index_reg,     index_next;
    logic [7:0]          sum_reg,       sum_next;
    logic [7:0]          error_reg,     error_next;
    logic [15:0]         position_reg,  position_next;

    logic [7:0]          sum_plus;
    logic [LEFT_W-1:0]   left_dec;

    assign sum_plus = sum_reg + rx_byte;
    assign left_dec = left_reg - LEFT_W'(1);

    // Next-state and result for the presented byte
    always_comb begin
        phase_next    = phase_reg;
        seen_next     = seen_reg;
        left_next     = left_reg;
        index_next    = index_reg;
        sum_next      = sum_reg;
        error_next    = error_reg;
        position_next = position_reg;
        result        = '{emit: 1'b0, status: ST_OK, device_error: 8'd0,
                          raw_position: 16'd0};

        unique case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == HEADER_BYTE) begin
                    if (seen_reg == 2'd2) begin
                        seen_next  = 2'd0;
                        phase_next = PH_ADDR;
                    end else begin
                        seen_next = seen_reg + 2'd1;
                    end
                end else begin
                    seen_next = 2'd0;
                end
            end
            PH_ADDR: begin
                if (rx_byte != own_address) begin
                    result.emit   = 1'b1;
                    result.status = ST_BAD_ADDR;
                    phase_next    = PH_HUNT;
                end else begin
                    sum_next   = rx_byte;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                if (rx_byte < LEN_MIN || rx_byte > LEN_MAX) begin
                    result.emit   = 1'b1;
                    result.status = ST_BAD_LEN;
                    phase_next    = PH_HUNT;
                end else begin
                    sum_next   = sum_plus;
                    left_next  = LEFT_W'(rx_byte - LEN_MIN);
                    phase_next = PH_ERR;
                end
            end
            PH_ERR: begin
                error_next    = rx_byte;
                sum_next      = sum_plus;
                index_next    = 2'd0;
                position_next = 16'd0;
                phase_next    = (left_reg == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                sum_next = sum_plus;
                // first two payload bytes form the little-endian position
                if (index_reg == 2'd0) begin
                    position_next[7:0] = rx_byte;
                end else if (index_reg == 2'd1) begin
                    position_next[15:8] = rx_byte;
                end
                if (index_reg != 2'd2) begin
                    index_next = index_reg + 2'd1;
                end
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                result.emit         = 1'b1;
                result.status       = (rx_byte == (HEADER_BYTE - sum_reg)) ? ST_OK
                                                                           : ST_BAD_SUM;
                result.device_error = error_reg;
                result.raw_position = position_reg;
                phase_next          = PH_HUNT;
                seen_next           = 2'd0;
            end
            default: begin
                phase_next = PH_HUNT;
                seen_next  = 2'd0;
            end
        endcase
    end

    // Parser state; only control state is reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            seen_reg  <= 2'd0;
            left_reg  <= '0;
            index_reg <= 2'd0;
        end else if (step) begin
            phase_reg    <= phase_next;
            seen_reg     <= seen_next;
            left_reg     <= left_next;
            index_reg    <= index_next;
            sum_reg      <= sum_next;
            error_reg    <= error_next;
            position_reg <= position_next;
        end
    end

endmodule : cfd_parser

`default_nettype wire

>>> design/checksummed_frame_deframer_core.sv
// ============================================================================
// checksummed_frame_deframer_core
// Status packet deframer: header hunt, address match, length and checksum
// checks, one status result per frame.
// ============================================================================
// Usage:
//   s_* carries received bytes, one per transaction, in arrival order.
//   m_* carries one result per completed or rejected frame: the status code
//   on m_tuser, the frame's error byte and 16-bit raw position on m_tdata.
//   cfg_* writes the own address; a frame whose address byte differs is
//   reported as wrong address. Write it only while the block is idle.
// Path: the byte that closes the frame is taken into the input register,
//   then its result is loaded into the result register, which drives
//   m_tvalid; while an earlier result still waits, the byte stays put.
// Throughput: one byte per cycle while no closing byte waits on a stalled result;
//   each register holds one transaction; the parser steps when its byte advances.
// Reset: parser returns to hunting the header, own address becomes 1,
//   both registers empty. cfg_ready is always high.
// Stall: while a result waits on m_tready, bytes that give no result keep
//   flowing; a byte that closes a frame waits in the input register until
//   the result register frees, and s_tready drops behind it.
// ============================================================================
`default_nettype none

module checksummed_frame_deframer_core
    import cfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Received bytes
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] rx_byte

    // Frame results
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,     // [7:0] device_error, [23:8] raw_position
    output      logic [1:0]  m_tuser,     // [1:0] frame_status

    // Own address write
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [7:0]  own_address_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic [1:0]  out_user_reg;

    cfd_result_t result;
    logic        advance;
    logic        out_load;

    // Parser
    cfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .own_address (own_address_reg),
        .result      (result)
    );

    // Held byte advances unless its result would overwrite a waiting one
    assign advance  = in_valid_reg && (!result.emit || !out_valid_reg || m_tready);
    assign out_load = advance && result.emit;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
            in_byte_reg  <= s_tdata;
        end
    end

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= 8'd1;
        end else if (cfg_valid) begin
            own_address_reg <= cfg_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= {result.raw_position, result.device_error};
            out_user_reg  <= result.status;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // A new result never lands on one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while stalled");

    // An accepted byte is held for the parser on the next cycle
    a_byte_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted byte lost");

    // A byte that cannot advance stays put
    a_byte_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held byte changed while blocked");
`endif

endmodule : checksummed_frame_deframer_core

`default_nettype wire
